/* rtl/playfair_digraph_cipher_unit_defines.svh */
// ----------------------------------------------------------------------------
// playfair cipher unit assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define PLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/plf_pkg.sv */
// ----------------------------------------------------------------------------
// plf_pkg
// types, codes and square helpers shared by the playfair cipher unit
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int SQ_SIDE     = 5;
  localparam int SQ_CELLS    = 25;
  localparam int NUM_LETTERS = 26;
  localparam int LTR_W       = 5;

  localparam logic [LTR_W-1:0] LETTER_J = 5'd9;

  // op codes
  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_ENCRYPT = 2'd2;
  localparam logic [1:0] OP_DECRYPT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_IN_SQ = 2'd1;
  localparam logic [1:0] ST_KEY_OPEN  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [LTR_W-1:0] letter_a;
    logic [LTR_W-1:0] letter_b;
  } in_t;

  typedef struct packed {
    logic [LTR_W-1:0] out_a;
    logic [LTR_W-1:0] out_b;
    logic [1:0]       status;
  } out_t;

  // cell coordinates inside the square
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  function automatic logic in_square(input logic [LTR_W-1:0] v);
    return (v < LTR_W'(NUM_LETTERS)) && (v != LETTER_J);
  endfunction

  // row * 5 + col
  function automatic logic [LTR_W-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

/* rtl/playfair_digraph_cipher_unit.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// 5x5 playfair key square builder with digraph encrypt and decrypt
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | plf_pkg::in_t
//   out     | output    | out_valid_o/out_stall_i | plf_pkg::out_t
//
// key letter: taken in the idle state, which it does not leave. finish key: the transfer,
// then a fill sweep over the alphabet, one letter per cycle. pair: place ram read, square
//   ram read, result register, output register load; an error status pair skips the ram reads
// reset clears the used flags, fill count and key state; no clearing pass
// a new item is taken while a result waits in the output register; a pair
// result waits in its final state until that register is free
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  plf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output plf_pkg::out_t out_data_o
);
  import plf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PLACE  = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [NUM_LETTERS-1:0] used_q, used_d;
  logic [LTR_W-1:0]       fill_q, fill_d;
  logic                   key_done_q, key_done_d;
  logic [LTR_W-1:0]       sweep_q, sweep_d;
  logic                   dec_q, dec_d;
  out_t                   res_q, res_d;
  out_t                   out_q;
  logic                   out_valid_q;

  logic                   in_xfer, out_xfer, out_load;
  logic [NUM_LETTERS-1:0] used_base;
  logic [LTR_W-1:0]       fill_base;
  logic                   wr_en;
  logic [LTR_W-1:0]       wr_letter, wr_cell;

  logic [LTR_W-1:0]       place_a, place_b, sq_a, sq_b;
  logic [LTR_W-1:0]       cell_a, cell_b;
  pos_t                   pos_a, pos_b;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    used_base  = used_q;
    fill_base  = fill_q;
    key_done_d = key_done_q;
    sweep_d    = sweep_q;
    dec_d      = dec_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    wr_letter  = sweep_q;
    wr_cell    = fill_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.op)
            OP_KEY: begin
              // a key letter after finish starts a fresh key
              if (key_done_q) begin
                used_base  = '0;
                fill_base  = '0;
                key_done_d = 1'b0;
              end
              wr_letter = in_data_i.letter_a;
              wr_cell   = fill_base;
              wr_en     = in_square(in_data_i.letter_a) &&
                          !used_base[in_data_i.letter_a] &&
                          (fill_base < LTR_W'(SQ_CELLS));
            end
            OP_FINISH: begin
              sweep_d = '0;
              state_d = S_FILL;
            end
            default: begin
              res_d.out_a = '0;
              res_d.out_b = '0;
              dec_d       = (in_data_i.op == OP_DECRYPT);
              if (!key_done_q) begin
                res_d.status = ST_KEY_OPEN;
                state_d      = S_OUT;
              end else if (!in_square(in_data_i.letter_a) ||
                           !in_square(in_data_i.letter_b)) begin
                res_d.status = ST_NOT_IN_SQ;
                state_d      = S_OUT;
              end else begin
                res_d.status = ST_OK;
                state_d      = S_PLACE;
              end
            end
          endcase
        end
      end
      S_PLACE: begin
        // place data is back; square read issued on the merged cells
        state_d = S_SQUARE;
      end
      S_SQUARE: begin
        res_d.out_a = sq_a;
        res_d.out_b = sq_b;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_FILL: begin
        wr_en = (sweep_q != LETTER_J) && !used_q[sweep_q] &&
                (fill_q < LTR_W'(SQ_CELLS));
        if (sweep_q == LTR_W'(NUM_LETTERS - 1)) begin
          key_done_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    used_d = used_base;
    fill_d = fill_base;
    if (wr_en) begin
      used_d[wr_letter] = 1'b1;
      fill_d            = fill_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      key_done_q  <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      fill_q     <= fill_d;
      key_done_q <= key_done_d;
      sweep_q    <= sweep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // letter -> cell index
  plf_ram #(
    .WIDTH (LTR_W),
    .DEPTH (NUM_LETTERS)
  ) u_place_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_letter),
    .wdata_i  (wr_cell),
    .raddr0_i (in_data_i.letter_a),
    .raddr1_i (in_data_i.letter_b),
    .rdata0_o (place_a),
    .rdata1_o (place_b)
  );

  plf_lane u_lane_a (
    .cell_i (place_a),
    .pos_o  (pos_a)
  );

  plf_lane u_lane_b (
    .cell_i (place_b),
    .pos_o  (pos_b)
  );

  plf_merge u_merge (
    .pos_a_i  (pos_a),
    .pos_b_i  (pos_b),
    .dec_i    (dec_q),
    .cell_a_o (cell_a),
    .cell_b_o (cell_b)
  );

  // cell index -> letter
  plf_ram #(
    .WIDTH (LTR_W),
    .DEPTH (SQ_CELLS)
  ) u_square_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_cell),
    .wdata_i  (wr_letter),
    .raddr0_i (cell_a),
    .raddr1_i (cell_b),
    .rdata0_o (sq_a),
    .rdata1_o (sq_b)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/plf_ram.sv */
// ----------------------------------------------------------------------------
// plf_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module plf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* rtl/plf_lane.sv */
// ----------------------------------------------------------------------------
// plf_lane
// splits one letter's cell index into row and column of the square
// ----------------------------------------------------------------------------
module plf_lane (
  input  logic [plf_pkg::LTR_W-1:0] cell_i,
  output plf_pkg::pos_t             pos_o
);
  import plf_pkg::*;

  logic [2:0]       row;
  logic [LTR_W-1:0] col_full;

  always_comb begin
    if (cell_i < 5'd5) begin
      row = 3'd0;
    end else if (cell_i < 5'd10) begin
      row = 3'd1;
    end else if (cell_i < 5'd15) begin
      row = 3'd2;
    end else if (cell_i < 5'd20) begin
      row = 3'd3;
    end else begin
      row = 3'd4;
    end
    col_full = cell_i - cell_of(row, 3'd0);
  end

  assign pos_o.row = row;
  assign pos_o.col = col_full[2:0];

endmodule

/* rtl/plf_merge.sv */
// ----------------------------------------------------------------------------
// plf_merge
// compares the two lane positions and picks the two output cells
// ----------------------------------------------------------------------------
module plf_merge (
  input  plf_pkg::pos_t             pos_a_i,
  input  plf_pkg::pos_t             pos_b_i,
  input  logic                      dec_i,
  output logic [plf_pkg::LTR_W-1:0] cell_a_o,
  output logic [plf_pkg::LTR_W-1:0] cell_b_o
);
  import plf_pkg::*;

  // one step forward or back, wrapping within the side
  function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
    logic [2:0] r;
    if (back) begin
      r = (x == 3'd0) ? 3'(SQ_SIDE - 1) : x - 3'd1;
    end else begin
      r = (x == 3'(SQ_SIDE - 1)) ? 3'd0 : x + 3'd1;
    end
    return r;
  endfunction

  always_comb begin
    if (pos_a_i.row == pos_b_i.row) begin
      // identical letters land here too
      cell_a_o = cell_of(pos_a_i.row, step5(pos_a_i.col, dec_i));
      cell_b_o = cell_of(pos_b_i.row, step5(pos_b_i.col, dec_i));
    end else if (pos_a_i.col == pos_b_i.col) begin
      cell_a_o = cell_of(step5(pos_a_i.row, dec_i), pos_a_i.col);
      cell_b_o = cell_of(step5(pos_b_i.row, dec_i), pos_b_i.col);
    end else begin
      cell_a_o = cell_of(pos_a_i.row, pos_b_i.col);
      cell_b_o = cell_of(pos_b_i.row, pos_a_i.col);
    end
  end

endmodule

/* rtl/plf_checker.sv */
// ----------------------------------------------------------------------------
// plf_checker
// port-level assertions for the playfair cipher unit, bound to the top level
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_unit_defines.svh"

module plf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input plf_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input plf_pkg::out_t out_data_o
);
  import plf_pkg::*;

  // a stalled result holds
  `PLF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // an error result carries zero letters
  `PLF_ASSERT_NOW(a_err_zero, out_valid_o && (out_data_o.status != ST_OK),
    (out_data_o.out_a == '0) && (out_data_o.out_b == '0), "error result with letters")

  // an ok result holds only square letters
  `PLF_ASSERT_NOW(a_ok_letters, out_valid_o && (out_data_o.status == ST_OK),
    in_square(out_data_o.out_a) && in_square(out_data_o.out_b), "result letter off square")

  // a key letter transfer leaves the input unstalled in the next cycle
  `PLF_ASSERT_NEXT(a_key_single, in_valid_i && !in_stall_o && (in_data_i.op == OP_KEY),
    !in_stall_o, "key letter held the input")

endmodule

bind playfair_digraph_cipher_unit plf_checker u_plf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* test/playfair_digraph_cipher_unit_tb.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit_tb
// drives key letters, key finish and digraph transfers into the cipher unit
// and checks every pair result against an in-bench model of the key square;
// a directed table covers the corner cases, then random keys and pairs follow
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit_tb;

  import plf_pkg::*;

  localparam int ITEM_TARGET  = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  // letter codes used by the directed table
  localparam logic [LTR_W-1:0] LT_A      = 5'd0;
  localparam logic [LTR_W-1:0] LT_B      = 5'd1;
  localparam logic [LTR_W-1:0] LT_C      = 5'd2;
  localparam logic [LTR_W-1:0] LT_E      = 5'd4;
  localparam logic [LTR_W-1:0] LT_L      = 5'd11;
  localparam logic [LTR_W-1:0] LT_M      = 5'd12;
  localparam logic [LTR_W-1:0] LT_P      = 5'd15;
  localparam logic [LTR_W-1:0] LT_U      = 5'd20;
  localparam logic [LTR_W-1:0] LT_Y      = 5'd24;
  localparam logic [LTR_W-1:0] LT_Z      = 5'd25;
  localparam logic [LTR_W-1:0] LT_OVER   = 5'd26;
  localparam logic [LTR_W-1:0] LT_ALL1   = 5'd31;

  localparam out_t NO_RES        = '0;
  localparam out_t KEY_OPEN_RES  = '{5'd0, 5'd0, ST_KEY_OPEN};
  localparam out_t NOT_IN_SQ_RES = '{5'd0, 5'd0, ST_NOT_IN_SQ};

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } dir_row_t;

  // key PLAY gives rows PLAYB / CDEFG / HIKMN / OQRST / UVWXZ
  localparam dir_row_t DIRECTED [0:24] = '{
    '{'{OP_ENCRYPT, LT_A,     LT_B},     1'b1, KEY_OPEN_RES},
    '{'{OP_DECRYPT, LT_ALL1,  LT_ALL1},  1'b1, KEY_OPEN_RES},
    '{'{OP_KEY,     LT_P,     LT_ALL1},  1'b0, NO_RES},
    '{'{OP_KEY,     LT_L,     LT_A},     1'b0, NO_RES},
    '{'{OP_KEY,     LT_A,     LT_Z},     1'b0, NO_RES},
    '{'{OP_KEY,     LT_A,     LT_A},     1'b0, NO_RES},
    '{'{OP_KEY,     LETTER_J, LT_A},     1'b0, NO_RES},
    '{'{OP_KEY,     LT_ALL1,  LT_A},     1'b0, NO_RES},
    '{'{OP_KEY,     LT_OVER,  LT_A},     1'b0, NO_RES},
    '{'{OP_ENCRYPT, LT_A,     LT_B},     1'b1, KEY_OPEN_RES},
    '{'{OP_KEY,     LT_Y,     LT_A},     1'b0, NO_RES},
    '{'{OP_FINISH,  LT_ALL1,  LT_ALL1},  1'b0, NO_RES},
    '{'{OP_FINISH,  LT_A,     LT_A},     1'b0, NO_RES},
    '{'{OP_ENCRYPT, LETTER_J, LT_A},     1'b1, NOT_IN_SQ_RES},
    '{'{OP_DECRYPT, LT_A,     LT_ALL1},  1'b1, NOT_IN_SQ_RES},
    '{'{OP_ENCRYPT, LT_OVER,  LETTER_J}, 1'b1, NOT_IN_SQ_RES},
    '{'{OP_ENCRYPT, LT_P,     LT_L},     1'b0, NO_RES},
    '{'{OP_DECRYPT, LT_P,     LT_L},     1'b0, NO_RES},
    '{'{OP_ENCRYPT, LT_A,     LT_A},     1'b0, NO_RES},
    '{'{OP_DECRYPT, LT_Z,     LT_Z},     1'b0, NO_RES},
    '{'{OP_ENCRYPT, LT_P,     LT_C},     1'b0, NO_RES},
    '{'{OP_DECRYPT, LT_P,     LT_U},     1'b0, NO_RES},
    '{'{OP_ENCRYPT, LT_L,     LT_E},     1'b0, NO_RES},
    '{'{OP_KEY,     LT_M,     LT_ALL1},  1'b0, NO_RES},
    '{'{OP_ENCRYPT, LT_A,     LT_B},     1'b1, KEY_OPEN_RES}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // key square model
  logic [LTR_W-1:0] sq_letter [SQ_CELLS];
  int               sq_cell   [NUM_LETTERS];
  bit [NUM_LETTERS-1:0] sq_used = '0;
  int               sq_fill   = 0;
  bit               sq_ready  = 1'b0;

  out_t pending_digraphs [$];
  int   mismatch_count  = 0;
  int   item_count      = 0;
  int   cycle_count     = 0;
  bit   quiet           = 1'b0;
  int   hold_req        = 0;
  int   hold_seen       = 0;
  int   hold_left       = 0;

  playfair_digraph_cipher_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit letter_ok(input logic [LTR_W-1:0] v);
    return (v < NUM_LETTERS) && (v != LETTER_J);
  endfunction

  function automatic logic [LTR_W-1:0] pick_letter();
    int v;
    v = $urandom_range(24);
    if (v >= LETTER_J) v++;
    return LTR_W'(v);
  endfunction

  task automatic place_letter(input logic [LTR_W-1:0] v);
    if (sq_fill < SQ_CELLS && !sq_used[v]) begin
      sq_letter[sq_fill] = v;
      sq_cell[v]         = sq_fill;
      sq_used[v]         = 1'b1;
      sq_fill++;
    end
  endtask

  // advances the square model by one transfer and gives the pair result, if any
  task automatic predict_digraph(input in_t item, output bit has_res, output out_t res);
    int ra, ca, rb, cb, na, nb, s;
    has_res = 1'b0;
    res     = '0;
    case (item.op)
      OP_KEY: begin
        // a key letter after finish starts a new key
        if (sq_ready) begin
          sq_used  = '0;
          sq_fill  = 0;
          sq_ready = 1'b0;
        end
        if (letter_ok(item.letter_a)) place_letter(item.letter_a);
      end
      OP_FINISH: begin
        for (int v = 0; v < NUM_LETTERS; v++) begin
          if (v != LETTER_J) place_letter(LTR_W'(v));
        end
        sq_ready = 1'b1;
      end
      default: begin
        has_res = 1'b1;
        if (!sq_ready) begin
          res.status = ST_KEY_OPEN;
        end else if (!letter_ok(item.letter_a) || !letter_ok(item.letter_b)) begin
          res.status = ST_NOT_IN_SQ;
        end else begin
          ra = sq_cell[item.letter_a] / SQ_SIDE;
          ca = sq_cell[item.letter_a] % SQ_SIDE;
          rb = sq_cell[item.letter_b] / SQ_SIDE;
          cb = sq_cell[item.letter_b] % SQ_SIDE;
          s  = (item.op == OP_ENCRYPT) ? 1 : SQ_SIDE - 1;
          if (ra == rb) begin
            na = ra * SQ_SIDE + (ca + s) % SQ_SIDE;
            nb = rb * SQ_SIDE + (cb + s) % SQ_SIDE;
          end else if (ca == cb) begin
            na = ((ra + s) % SQ_SIDE) * SQ_SIDE + ca;
            nb = ((rb + s) % SQ_SIDE) * SQ_SIDE + cb;
          end else begin
            na = ra * SQ_SIDE + cb;
            nb = rb * SQ_SIDE + ca;
          end
          res.out_a  = sq_letter[na];
          res.out_b  = sq_letter[nb];
          res.status = ST_OK;
        end
      end
    endcase
  endtask

  // offers one item until its transfer, then records the expected pair result
  task automatic send_item(input in_t item, input bit typed, input out_t want);
    bit   has_res;
    out_t res;
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digraph(item, has_res, res);
    if (has_res) pending_digraphs = {pending_digraphs, (typed ? want : res)};
    item_count++;
  endtask

  task automatic report_failure(input out_t got, input out_t want, input bit orphan);
    if (mismatch_count < REPORT_MAX) begin
      if (orphan) begin
        $display("unexpected result: a=%0d b=%0d status=%0d",
                 got.out_a, got.out_b, got.status);
      end else begin
        $display("mismatch: got a=%0d b=%0d status=%0d, want a=%0d b=%0d status=%0d",
                 got.out_a, got.out_b, got.status, want.out_a, want.out_b, want.status);
      end
    end
    mismatch_count++;
  endtask

  // result side: checks transfers and drives the stall
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_digraphs.size() == 0) begin
          report_failure(out_data_o, NO_RES, 1'b1);
        end else begin
          want = pending_digraphs.pop_front();
          if (out_data_o.out_a !== want.out_a || out_data_o.out_b !== want.out_b ||
              out_data_o.status !== want.status) begin
            report_failure(out_data_o, want, 1'b0);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen   <= hold_req;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_t item;
    int  n_key;
    int  n_pairs;
    bit  hold_done;
    hold_done   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    // random keys, each followed by a burst of pairs
    while (item_count < ITEM_TARGET) begin
      n_key = $urandom_range(30);
      for (int k = 0; k < n_key; k++) begin
        item.op       = OP_KEY;
        item.letter_a = ($urandom_range(9) == 0) ? LTR_W'($urandom_range(31)) : pick_letter();
        item.letter_b = LTR_W'($urandom_range(31));
        send_item(item, 1'b0, NO_RES);
        // pair sent while the key is still open
        if ($urandom_range(19) == 0) begin
          item.op = ($urandom_range(1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
          item.letter_a = LTR_W'($urandom_range(31));
          send_item(item, 1'b0, NO_RES);
        end
      end
      if ($urandom_range(9) != 0) begin
        item.op       = OP_FINISH;
        item.letter_a = LTR_W'($urandom_range(31));
        item.letter_b = LTR_W'($urandom_range(31));
        send_item(item, 1'b0, NO_RES);
        if ($urandom_range(9) == 0) send_item(item, 1'b0, NO_RES);
      end
      n_pairs = $urandom_range(5, 40);
      for (int p = 0; p < n_pairs; p++) begin
        item.op       = ($urandom_range(1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
        item.letter_a = ($urandom_range(11) == 0) ? LTR_W'($urandom_range(31)) : pick_letter();
        item.letter_b = ($urandom_range(11) == 0) ? LTR_W'($urandom_range(31)) : pick_letter();
        // identical letters now and then
        if ($urandom_range(15) == 0) item.letter_b = item.letter_a;
        send_item(item, 1'b0, NO_RES);
      end
      if (item_count >= 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_req++;
      end
      quiet = (item_count >= 700) && (item_count < 900);
    end
    in_valid_i <= 1'b0;

    while (pending_digraphs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_digraphs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/plf_pkg.sv
rtl/plf_ram.sv
rtl/plf_lane.sv
rtl/plf_merge.sv
rtl/playfair_digraph_cipher_unit.sv
rtl/plf_checker.sv
test/playfair_digraph_cipher_unit_tb.sv
